@@ rtl/core/depth_pixel_backprojection_defines.svh @@
// Assertion macros used by the block's queue module.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Check an implication in the same cycle, outside reset.
`define DPB_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check an implication in the next cycle, outside reset.
`define DPB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/dpb_pkg.sv @@
package dpb_pkg;

  // Defaults for the top level parameters
  localparam int COORD_BITS_DEF     = 12;
  localparam int SUBSAMPLE_STEP_DEF = 2;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_INV_DEPTH_SCALE = 3'd2,
    REG_CENTER_X        = 3'd3,
    REG_CENTER_Y        = 3'd4,
    REG_INV_FOCAL_X     = 3'd5,
    REG_INV_FOCAL_Y     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [23:0] inv_depth_scale;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:     13'd640,
    image_height:    13'd480,
    inv_depth_scale: 24'd16777,
    center_x:        16'd5208,
    center_y:        16'd4056,
    inv_focal_x:     24'd32389,
    inv_focal_y:     24'd32326
  };

  typedef struct packed {
    logic [15:0] depth_value;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [23:0]        point_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } point_t;

  // Width of one queued pixel: depth, three color bytes, column and row
  function automatic int entry_width(int coord_bits);
    return 40 + 2 * coord_bits;
  endfunction

endpackage

@@ rtl/core/dpb_regs.sv @@
module dpb_regs
  import dpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Write the addressed register, masked to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      case (idx)
        REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[12:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= pwdata[12:0];
        REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= pwdata[23:0];
        REG_CENTER_X:        cfg.center_x        <= pwdata[15:0];
        REG_CENTER_Y:        cfg.center_y        <= pwdata[15:0];
        REG_INV_FOCAL_X:     cfg.inv_focal_x     <= pwdata[23:0];
        REG_INV_FOCAL_Y:     cfg.inv_focal_y     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:     prdata = DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT:    prdata = DATA_W'(cfg.image_height);
      REG_INV_DEPTH_SCALE: prdata = DATA_W'(cfg.inv_depth_scale);
      REG_CENTER_X:        prdata = DATA_W'(cfg.center_x);
      REG_CENTER_Y:        prdata = DATA_W'(cfg.center_y);
      REG_INV_FOCAL_X:     prdata = DATA_W'(cfg.inv_focal_x);
      REG_INV_FOCAL_Y:     prdata = DATA_W'(cfg.inv_focal_y);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/dpb_front.sv @@
module dpb_front
  import dpb_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
  parameter int ENT_W          = entry_width(COORD_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  pixel_t           pixel,
  input  logic             q_full,
  output logic             push,
  output logic [ENT_W-1:0] push_data
);

  localparam int CMP_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
  localparam int PH_W  = (SUBSAMPLE_STEP > 1) ? $clog2(SUBSAMPLE_STEP) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(SUBSAMPLE_STEP - 1);

  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [PH_W-1:0]       col_ph;
  logic [PH_W-1:0]       row_ph;
  logic                  col_last;
  logic                  row_last;
  logic                  accept;
  logic                  keep;

  assign pixel_ready = !q_full;
  assign accept      = pixel_valid && pixel_ready;

  // Wrap at the configured size or at the counter's top value
  assign col_last = (CMP_W'(col) + CMP_W'(1) >= CMP_W'(cfg.image_width)) || (&col);
  assign row_last = (CMP_W'(row) + CMP_W'(1) >= CMP_W'(cfg.image_height)) || (&row);

  // Advance raster position and subsample phases on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      col_ph <= '0;
      row_ph <= '0;
    end else if (accept) begin
      if (col_last) begin
        col    <= '0;
        col_ph <= '0;
        if (row_last) begin
          row    <= '0;
          row_ph <= '0;
        end else begin
          row    <= row + 1'b1;
          row_ph <= (row_ph == PH_LAST) ? '0 : row_ph + 1'b1;
        end
      end else begin
        col    <= col + 1'b1;
        col_ph <= (col_ph == PH_LAST) ? '0 : col_ph + 1'b1;
      end
    end
  end

  // Keep on-grid pixels that carry a depth measurement
  assign keep      = (col_ph == '0) && (row_ph == '0) && (pixel.depth_value != '0);
  assign push      = accept && keep;
  assign push_data = {row, col, pixel.red, pixel.green, pixel.blue, pixel.depth_value};

endmodule

@@ rtl/core/dpb_queue.sv @@
`include "depth_pixel_backprojection_defines.svh"

module dpb_queue
  import dpb_pkg::*;
#(
  parameter int WIDTH = entry_width(COORD_BITS_DEF),
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slot[rd_ptr];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DPB_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue written while full")
  `DPB_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
  `DPB_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(count), "queue count moved while idle")

endmodule

@@ rtl/core/dpb_back.sv @@
module dpb_back
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENT_W      = entry_width(COORD_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  logic [ENT_W-1:0] q_data,
  output logic             pop,
  output logic             point_valid,
  input  logic             point_ready,
  output point_t           point
);

  // Offset from the principal point, signed Q.4
  localparam int D_W = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1;
  localparam int P_W = D_W + 25;   // offset times z
  localparam int T_W = P_W - 4;    // after the Q.4 shift
  localparam int H_W = T_W - 20;   // signed upper part of t
  localparam int S_W = D_W + 47;   // full t times reciprocal
  localparam int R_W = S_W - 24;   // after the Q0.24 shift

  logic advance;
  logic v1, v2, v3, v4, v5;

  // Entry fields
  logic [15:0]           e_depth;
  logic [23:0]           e_color;
  logic [COORD_BITS-1:0] e_col;
  logic [COORD_BITS-1:0] e_row;

  // Stage registers
  logic [39:0]            pz1;
  logic signed [D_W-1:0]  dx1, dy1, dx2, dy2;
  logic [23:0]            c1, c2, c3, c4, c5;
  logic [23:0]            z2, z3, z4, z5;
  logic [23:0]            z_sat;
  logic signed [P_W-1:0]  px3, py3;
  logic signed [T_W-1:0]  tx, ty;
  logic signed [H_W+24:0] phx4, phy4;
  logic [43:0]            plx4, ply4;
  logic signed [S_W-1:0]  sx5, sy5;

  assign {e_row, e_col, e_color, e_depth} = q_data;

  // Stall the whole pipe while a result waits at the output
  assign advance = !point_valid || point_ready;
  assign pop     = advance && !q_empty;

  // Saturate a shifted product to signed 24 bits
  function automatic logic [23:0] sat24(input logic [R_W-1:0] r);
    logic fits;
    fits = (&r[R_W-1:23]) || !(|r[R_W-1:23]);
    if (fits) begin
      return r[23:0];
    end else if (r[R_W-1]) begin
      return 24'h800000;
    end else begin
      return 24'h7FFFFF;
    end
  endfunction

  assign z_sat = (|pz1[39:32]) ? 24'hFFFFFF : pz1[31:8];
  assign tx    = px3[P_W-1:4];
  assign ty    = py3[P_W-1:4];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      v5          <= 1'b0;
      point_valid <= 1'b0;
    end else if (advance) begin
      v1          <= pop;
      v2          <= v1;
      v3          <= v2;
      v4          <= v3;
      v5          <= v4;
      point_valid <= v5;
    end
  end

  // Carry payload through the stages
  always_ff @(posedge clk) begin
    if (advance) begin
      // depth scale and principal point offsets
      pz1 <= 40'(e_depth) * 40'(cfg.inv_depth_scale);
      dx1 <= $signed(D_W'({e_col, 4'b0000})) - $signed(D_W'(cfg.center_x));
      dy1 <= $signed(D_W'({e_row, 4'b0000})) - $signed(D_W'(cfg.center_y));
      c1  <= e_color;
      // saturate z
      z2  <= z_sat;
      dx2 <= dx1;
      dy2 <= dy1;
      c2  <= c1;
      // offset times z
      px3 <= dx2 * $signed({1'b0, z2});
      py3 <= dy2 * $signed({1'b0, z2});
      z3  <= z2;
      c3  <= c2;
      // partial products against the focal reciprocals
      phx4 <= $signed(tx[T_W-1:20]) * $signed({1'b0, cfg.inv_focal_x});
      phy4 <= $signed(ty[T_W-1:20]) * $signed({1'b0, cfg.inv_focal_y});
      plx4 <= 44'(tx[19:0]) * 44'(cfg.inv_focal_x);
      ply4 <= 44'(ty[19:0]) * 44'(cfg.inv_focal_y);
      z4   <= z3;
      c4   <= c3;
      // combine partial products
      sx5 <= (S_W'(phx4) <<< 20) + $signed(S_W'(plx4));
      sy5 <= (S_W'(phy4) <<< 20) + $signed(S_W'(ply4));
      z5  <= z4;
      c5  <= c4;
      // floor shift, saturate and hold for the consumer
      point.point_x   <= sat24(sx5[S_W-1:24]);
      point.point_y   <= sat24(sy5[S_W-1:24]);
      point.point_z   <= z5;
      point.out_red   <= c5[23:16];
      point.out_green <= c5[15:8];
      point.out_blue  <= c5[7:0];
    end
  end

endmodule

@@ rtl/core/depth_pixel_backprojection.sv @@
// A kept pixel is written into the entry queue, then moves through the pipeline to
// point_valid. Throughput: one pixel per cycle while point_ready is high and the
// queue is not full, set by the six-stage pipeline (five arithmetic stages and the
// output register) behind the entry queue, one queued pixel per unstalled clock.
// Reset: registers return to their defaults, raster counters to zero, queue and
// pipeline empty; the block accepts pixels on the cycle after reset drops.
module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SUBSAMPLE_STEP = SUBSAMPLE_STEP_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  pixel_t            pixel,
  output logic              point_valid,
  input  logic              point_ready,
  output point_t            point
);

  localparam int ENT_W = entry_width(COORD_BITS);

  cfg_t             cfg;
  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_pop;
  logic [ENT_W-1:0] q_pop_data;
  logic             q_full;
  logic             q_empty;

  dpb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpb_front #(
    .COORD_BITS     (COORD_BITS),
    .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
    .ENT_W          (ENT_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .q_full      (q_full),
    .push        (q_push),
    .push_data   (q_push_data)
  );

  dpb_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  dpb_back #(
    .COORD_BITS (COORD_BITS),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_pop_data),
    .pop         (q_pop),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point)
  );

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import dpb_pkg::*;

  localparam int     REG_UNUSED   = 7;
  localparam int     COORD_MAX    = (1 << COORD_BITS_DEF) - 1;
  localparam int     SUBSAMPLE    = SUBSAMPLE_STEP_DEF;
  localparam int     SETTLE       = 16;
  localparam int     LONG_HOLD    = 300;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     PRINT_LIMIT  = 100;
  localparam longint Z_MAX        = 64'h0000_0000_00FF_FFFF;
  localparam longint SAT_HI       = 8388607;
  localparam longint SAT_LO       = -8388608;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pixel_valid = 1'b0;
  logic              pixel_ready;
  pixel_t            pixel = '0;
  logic              point_valid;
  logic              point_ready = 1'b0;
  point_t            point;

  depth_pixel_backprojection dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixel_valid, .pixel_ready, .pixel, .point_valid, .point_ready, .point
  );

  // Shadow of the block: configuration and raster position
  cfg_t   model_cfg = CFG_RESET;
  int     raster_col = 0;
  int     raster_row = 0;
  point_t expected_points[$];
  pixel_t pixel_backlog[$];

  int     pixels_queued = 0;
  int     pixels_issued = 0;
  int     pixels_accepted = 0;
  int     points_checked = 0;
  logic   points_idle = 1'b1;
  int     error_count = 0;
  int     cycle_count = 0;

  int     send_idle_pct = 23;
  int     recv_idle_pct = 57;
  logic   hold_armed = 1'b0;
  logic   long_hold_done = 1'b0;
  int     hold_left = 0;
  int     drain_at = -1;
  logic   drain_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Project one pixel axis: offset from the principal point, scaled by depth and 1/f
  function automatic logic [23:0] axis_coord(input int pos, input logic [15:0] center,
                                             input longint z, input logic [23:0] inv_f);
    longint d, t, v;
    d = longint'(pos) * 16 - longint'(center);
    t = (d * z) >>> 4;
    v = (t * longint'(inv_f)) >>> 24;
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return v[23:0];
  endfunction

  // Advance the raster position and queue the point a kept pixel yields
  task automatic back_project(input pixel_t px);
    int     c, r;
    longint zq, z;
    point_t pt;
    c = raster_col;
    r = raster_row;
    if (c + 1 >= model_cfg.image_width || c >= COORD_MAX) begin
      raster_col = 0;
      if (r + 1 >= model_cfg.image_height || r >= COORD_MAX) raster_row = 0;
      else raster_row = r + 1;
    end else begin
      raster_col = c + 1;
    end
    if (c % SUBSAMPLE == 0 && r % SUBSAMPLE == 0 && px.depth_value != 0) begin
      zq = (longint'(px.depth_value) * longint'(model_cfg.inv_depth_scale)) >>> 8;
      z = (zq > Z_MAX) ? Z_MAX : zq;
      pt.point_x   = axis_coord(c, model_cfg.center_x, z, model_cfg.inv_focal_x);
      pt.point_y   = axis_coord(r, model_cfg.center_y, z, model_cfg.inv_focal_y);
      pt.point_z   = z[23:0];
      pt.out_blue  = px.blue;
      pt.out_green = px.green;
      pt.out_red   = px.red;
      expected_points = {expected_points, pt};
    end
  endtask

  // Feed pixels from the backlog; pause once to let every point drain
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pixel_ready) begin
      if (pixels_issued == drain_at && !drain_done) begin
        pixel_valid <= 1'b0;
        if (!pixel_valid && points_idle) drain_done <= 1'b1;
      end else if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel         <= pixel_backlog.pop_front();
        pixel_valid   <= 1'b1;
        pixels_issued <= pixels_issued + 1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Stall the point side at random, and once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      point_ready <= 1'b0;
    end else if (hold_left != 0) begin
      point_ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_armed && !long_hold_done && pixel_valid) begin
      point_ready    <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      point_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each point transfer against the oldest expectation, then predict new ones
  always @(posedge clk) begin
    point_t want;
    if (!rst) begin
      if (point_valid && point_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point transfer with no expected point pending");
        end else begin
          want = expected_points.pop_front();
          if (point.point_x !== want.point_x)
            report_mismatch($sformatf("point_x got %0d expected %0d", point.point_x,
                                      want.point_x));
          if (point.point_y !== want.point_y)
            report_mismatch($sformatf("point_y got %0d expected %0d", point.point_y,
                                      want.point_y));
          if (point.point_z !== want.point_z)
            report_mismatch($sformatf("point_z got %0h expected %0h", point.point_z,
                                      want.point_z));
          if (point.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue got %0h expected %0h", point.out_blue,
                                      want.out_blue));
          if (point.out_green !== want.out_green)
            report_mismatch($sformatf("out_green got %0h expected %0h", point.out_green,
                                      want.out_green));
          if (point.out_red !== want.out_red)
            report_mismatch($sformatf("out_red got %0h expected %0h", point.out_red,
                                      want.out_red));
        end
        points_checked <= points_checked + 1;
      end
      if (pixel_valid && pixel_ready) begin
        back_project(pixel);
        pixels_accepted <= pixels_accepted + 1;
      end
      points_idle <= (expected_points.size() == 0);
    end
  end

  // One register write: setup cycle, then access cycle
  task automatic cfg_write(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     model_cfg.image_width     = value[12:0];
      REG_IMAGE_HEIGHT:    model_cfg.image_height    = value[12:0];
      REG_INV_DEPTH_SCALE: model_cfg.inv_depth_scale = value[23:0];
      REG_CENTER_X:        model_cfg.center_x        = value[15:0];
      REG_CENTER_Y:        model_cfg.center_y        = value[15:0];
      REG_INV_FOCAL_X:     model_cfg.inv_focal_x     = value[23:0];
      REG_INV_FOCAL_Y:     model_cfg.inv_focal_y     = value[23:0];
      default: ;
    endcase
  endtask

  task automatic push_pixel(input pixel_t px);
    pixel_backlog = {pixel_backlog, px};
    pixels_queued++;
  endtask

  // Wait for every pixel to transfer and every point to arrive, then let the pipe empty
  task automatic wait_drained();
    while (pixels_accepted != pixels_queued || !points_idle) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(9))
      0, 1:    px.depth_value = 16'h0000;
      2:       px.depth_value = 16'hFFFF;
      3:       px.depth_value = 16'($urandom_range(15, 1));
      default: px.depth_value = 16'($urandom);
    endcase
    px.blue  = 8'($urandom);
    px.green = 8'($urandom);
    px.red   = 8'($urandom);
    return px;
  endfunction

  function automatic logic [31:0] random_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(12, 1);
      5, 6:          return $urandom_range(80, 13);
      7:             return 32'd0;
      8:             return $urandom_range(8191, 4096);
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_recip(input int lo, input int hi);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(hi, lo);
      4, 5, 6:    return $urandom;
      7:          return 32'd0;
      8:          return 32'h00FF_FFFF;
      default:    return $urandom_range(255, 1);
    endcase
  endfunction

  function automatic logic [31:0] random_center();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(2000, 0);
      5:             return 32'h0000_FFFF;
      6:             return 32'd0;
      default:       return $urandom;
    endcase
  endfunction

  task automatic pick_random_settings();
    cfg_write(REG_IMAGE_WIDTH, random_size());
    cfg_write(REG_IMAGE_HEIGHT, random_size());
    cfg_write(REG_INV_DEPTH_SCALE, random_recip(1000, 70000));
    cfg_write(REG_CENTER_X, random_center());
    cfg_write(REG_CENTER_Y, random_center());
    cfg_write(REG_INV_FOCAL_X, random_recip(10000, 70000));
    cfg_write(REG_INV_FOCAL_Y, random_recip(10000, 70000));
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: row 0 with depth extremes, zero depth and odd columns
    @(negedge clk);
    push_pixel('{16'hFFFF, 8'hFF, 8'h00, 8'hFF});
    push_pixel('{16'h1234, 8'h55, 8'hAA, 8'h55});
    push_pixel('{16'h0000, 8'hFF, 8'hFF, 8'hFF});
    push_pixel('{16'h00FF, 8'h00, 8'h00, 8'h00});
    push_pixel('{16'h0001, 8'h00, 8'hFF, 8'h00});
    push_pixel('{16'hFFFF, 8'h12, 8'h34, 8'h56});
    push_pixel('{16'h8000, 8'hA5, 8'h5A, 8'hC3});
    push_pixel('{16'h7FFF, 8'h01, 8'h80, 8'hFE});
    wait_drained();

    // Saturation corners: full reciprocals, center at either end; upper bits masked
    cfg_write(REG_IMAGE_WIDTH, 32'hFFFF_E008);
    cfg_write(REG_IMAGE_HEIGHT, 32'd4);
    cfg_write(REG_INV_DEPTH_SCALE, 32'hFFFF_FFFF);
    cfg_write(REG_CENTER_X, 32'd0);
    cfg_write(REG_CENTER_Y, 32'hFFFF_FFFF);
    cfg_write(REG_INV_FOCAL_X, 32'hFFFF_FFFF);
    cfg_write(REG_INV_FOCAL_Y, 32'hFFFF_FFFF);
    @(negedge clk);
    push_pixel('{16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
    push_pixel('{16'hFFFF, 8'h00, 8'h00, 8'h00});
    push_pixel('{16'h0001, 8'h11, 8'h22, 8'h33});
    push_pixel('{16'hFFFF, 8'h44, 8'h55, 8'h66});
    push_pixel('{16'hFFFF, 8'h77, 8'h88, 8'h99});
    push_pixel('{16'h0000, 8'hAA, 8'hBB, 8'hCC});
    push_pixel('{16'hFFFF, 8'hDD, 8'hEE, 8'hFF});
    push_pixel('{16'h0100, 8'h0F, 8'hF0, 8'h3C});
    push_pixel('{16'hFFFF, 8'hC3, 8'h3C, 8'h0F});
    push_pixel('{16'h0001, 8'hFF, 8'h00, 8'hFF});
    wait_drained();

    // Zero width and height written through masked bits; write past the register list
    cfg_write(REG_IMAGE_WIDTH, 32'h0000_2000);
    cfg_write(REG_IMAGE_HEIGHT, 32'h0000_4000);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(REG_INV_DEPTH_SCALE, 32'd16777);
    cfg_write(REG_CENTER_X, 32'h0000_FFFF);
    cfg_write(REG_INV_FOCAL_X, 32'd32389);
    @(negedge clk);
    push_pixel('{16'h0400, 8'h01, 8'h02, 8'h03});
    push_pixel('{16'h0000, 8'h04, 8'h05, 8'h06});
    push_pixel('{16'hFFFF, 8'h07, 8'h08, 8'h09});
    push_pixel('{16'h0002, 8'hFF, 8'hFF, 8'hFF});
    push_pixel('{16'hABCD, 8'h00, 8'h00, 8'h00});
    wait_drained();

    // Random frames, one setting per phase; rotate the idle pattern
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 57;
        recv_idle_pct = 23;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_random_settings();
      // Single-pixel frame keeps every measured pixel, so the long hold fills the block
      if (ph == 3) begin
        cfg_write(REG_IMAGE_WIDTH, 32'd1);
        cfg_write(REG_IMAGE_HEIGHT, 32'd1);
      end
      @(negedge clk);
      if (ph == 3) hold_armed = 1'b1;
      if (ph == 10) drain_at = pixels_issued + 30;
      repeat ($urandom_range(100, 60)) push_pixel(random_pixel());
      wait_drained();
    end

    repeat (32) @(posedge clk);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
